### hdl/dwc3s2_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwc3s2_pkg: shared types and constants
// Register indexes, fixed field widths and config structs that the depthwise
// 3x3 stride-2 unit hands from its registers to its front and back ends.
// ----------------------------------------------------------------------------
package dwc3s2_pkg;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 48;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IN_WIDTH      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IN_HEIGHT     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_WIDTH     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_HEIGHT    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_TOP    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_MIDDLE = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_BOTTOM = 3'd6;

  // Register field widths
  localparam int IN_WIDTH_BITS   = 11;
  localparam int IN_HEIGHT_BITS  = 13;
  localparam int OUT_WIDTH_BITS  = 9;
  localparam int OUT_HEIGHT_BITS = 11;
  localparam int KERNEL_BITS     = 48;

  // Plane height limit and row counter
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_BITS   = 12;

  // Result width (signed Q14.22)
  localparam int SUM_BITS = 36;

  // Output plane size
  typedef struct packed {
    logic [OUT_WIDTH_BITS-1:0]  out_width;
    logic [OUT_HEIGHT_BITS-1:0] out_height;
  } outdim_t;

  // Packed kernel rows, weight 0 in the low bits of each row
  typedef struct packed {
    logic [KERNEL_BITS-1:0] top;
    logic [KERNEL_BITS-1:0] middle;
    logic [KERNEL_BITS-1:0] bottom;
  } kern_t;

endpackage
`default_nettype wire

### hdl/dwc3s2_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwc3s2_ram: generic single-write, single-read RAM
// One write port, one read port with registered data. A read of the address
// being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module dwc3s2_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first array
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

### hdl/dwc3s2_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwc3s2_queue: short window queue between front and back ends
// Holds complete 3x3 windows waiting for the multiply pipeline so that the
// pixel intake and the result side stall independently.
// ----------------------------------------------------------------------------
module dwc3s2_queue #(
  parameter int WIDTH = 145,
  parameter int DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire [WIDTH-1:0]  wdata,
  input  wire              pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PB-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PB-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CB-1:0]    count_r,  count_nxt;

  assign full  = (count_r == CB'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PB'(DEPTH - 1)) ? '0 : wr_ptr_r + PB'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PB'(DEPTH - 1)) ? '0 : rd_ptr_r + PB'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CB'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

### hdl/dwc3s2_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwc3s2_front: pixel intake, line stores and window tracking
// Accepts one pixel per cycle while the queue is not full, keeps the two rows
// above in line stores and the two columns to the left in a window register,
// and queues each 3x3 window the current pixel closes on the stride-2 grid.
// ----------------------------------------------------------------------------
module dwc3s2_front
  import dwc3s2_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                restart,
  input  wire [$clog2(MAX_WIDTH)-1:0]        col_last,
  input  wire [ROW_BITS-1:0]                 row_last,
  input  outdim_t                            odim,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire signed [PIXEL_BITS-1:0]        in_pixel,
  input  wire                                q_full,
  output logic                               job_push,
  output logic [9*PIXEL_BITS:0]              job_data
);

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int P  = PIXEL_BITS;

  logic          accept;
  logic [CB-1:0] col_r, col_nxt;
  logic [ROW_BITS-1:0] row_r, row_nxt;
  logic          col_end;
  logic [P-1:0]  older_q, newer_q;
  logic [P-1:0]  win_r [6];
  logic [CB-1:0] col_m2;
  logic [ROW_BITS-1:0] row_m2;
  logic [31:0]   ox, oy;
  logic          on_grid;
  logic          last;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign col_end  = (col_r == col_last);

  // raster position counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = (row_r == row_last) ? '0 : row_r + ROW_BITS'(1);
      end else begin
        col_nxt = col_r + CB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line stores: read ahead at the next column, write back at the current
  dwc3s2_ram #(
    .WIDTH (P),
    .DEPTH (MAX_WIDTH)
  ) u_line_older (
    .clk   (clk),
    .we    (accept),
    .waddr (col_r),
    .wdata (newer_q),
    .raddr (col_nxt),
    .rdata (older_q)
  );

  dwc3s2_ram #(
    .WIDTH (P),
    .DEPTH (MAX_WIDTH)
  ) u_line_newer (
    .clk   (clk),
    .we    (accept),
    .waddr (col_r),
    .wdata (in_pixel),
    .raddr (col_nxt),
    .rdata (newer_q)
  );

  // window: two columns left of the current pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (accept) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= older_q;
      win_r[4] <= newer_q;
      win_r[5] <= in_pixel;
    end
  end

  // stride-2 grid test and output bounds
  always_comb begin
    col_m2  = col_r - CB'(2);
    row_m2  = row_r - ROW_BITS'(2);
    ox      = 32'(col_m2 >> 1);
    oy      = 32'(row_m2 >> 1);
    on_grid = (col_r >= CB'(2)) && (row_r >= ROW_BITS'(2)) &&
              !col_r[0] && !row_r[0] &&
              (ox < 32'(odim.out_width)) && (oy < 32'(odim.out_height));
    last    = ((ox + 32'd1) == 32'(odim.out_width)) &&
              ((oy + 32'd1) == 32'(odim.out_height));
  end

  // window packing: tap (row k, col j) at slot 3k+j
  assign job_push = accept && on_grid;
  assign job_data = {last,
                     in_pixel, win_r[5], win_r[2],
                     newer_q,  win_r[4], win_r[1],
                     older_q,  win_r[3], win_r[0]};

endmodule
`default_nettype wire

### hdl/dwc3s2_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwc3s2_back: multiply-accumulate pipeline and result register
// Pops one queued window per cycle: nine products, three row sums, then the
// final sum into the output register. The whole pipeline holds on a stall.
// ----------------------------------------------------------------------------
module dwc3s2_back
  import dwc3s2_pkg::*;
#(
  parameter int PIXEL_BITS  = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  kern_t                       kern,
  input  wire [9*PIXEL_BITS:0]        q_data,
  input  wire                         q_empty,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic signed [SUM_BITS-1:0]  out_sum,
  output logic                        out_last_of_plane
);

  localparam int P   = PIXEL_BITS;
  localparam int W   = WEIGHT_BITS;
  localparam int PW  = P + W;
  localparam int ACC = (PW + 4 > SUM_BITS) ? PW + 4 : SUM_BITS;

  logic [2*KERNEL_BITS-1:0] krow_ext [3];
  logic signed [W-1:0]      wt  [9];
  logic signed [P-1:0]      pix [9];
  logic signed [PW-1:0]     prod_nxt [9];
  logic signed [PW-1:0]     prod_r   [9];
  logic signed [ACC-1:0]    rsum_nxt [3];
  logic signed [ACC-1:0]    rsum_r   [3];
  logic signed [ACC-1:0]    total_nxt;
  logic                     en;
  logic                     s1_valid_r, s2_valid_r, out_valid_r;
  logic                     s1_last_r, s2_last_r, out_last_r;
  logic signed [SUM_BITS-1:0] out_sum_r;

  // weight unpacking, zero above the 48-bit row
  assign krow_ext[0] = {{KERNEL_BITS{1'b0}}, kern.top};
  assign krow_ext[1] = {{KERNEL_BITS{1'b0}}, kern.middle};
  assign krow_ext[2] = {{KERNEL_BITS{1'b0}}, kern.bottom};

  for (genvar k = 0; k < 3; k++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_tap
      assign wt[3*k+j]  = krow_ext[k][j*W +: W];
      assign pix[3*k+j] = q_data[(3*k+j)*P +: P];
    end
  end

  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && !q_empty;

  // stage 1: nine products
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      prod_nxt[i] = pix[i] * wt[i];
    end
  end

  // stage 2: row sums
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsum_nxt[k] = ACC'(prod_r[3*k]) + ACC'(prod_r[3*k+1]) + ACC'(prod_r[3*k+2]);
    end
  end

  // stage 3: final sum
  assign total_nxt = rsum_r[0] + rsum_r[1] + rsum_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= q_pop;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
      for (int k = 0; k < 3; k++) begin
        rsum_r[k] <= rsum_nxt[k];
      end
      s1_last_r  <= q_data[9*P];
      s2_last_r  <= s1_last_r;
      out_last_r <= s2_last_r;
      out_sum_r  <= total_nxt[SUM_BITS-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sum           = out_sum_r;
  assign out_last_of_plane = out_last_r;

endmodule
`default_nettype wire

### hdl/depthwise_conv3x3_stride2_unit.sv
// Each window passes the queue, product, row-sum and output registers.
// Throughput: one pixel per cycle while the queue is not full; the multiply
// pipeline takes one window per cycle unless the output stalls, and a 4-entry
// window queue absorbs output stalls. Reset: synchronous, active low; clears
// counters, window and queue and loads the config defaults. The line stores
// are not cleared and need no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// depthwise_conv3x3_stride2_unit: streaming 3x3 depthwise conv, stride 2
// Configuration registers, front end (line stores, window, grid test),
// window queue and multiply-accumulate back end for one channel plane.
// ----------------------------------------------------------------------------
module depthwise_conv3x3_stride2_unit
  import dwc3s2_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int PIXEL_BITS  = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // configuration
  input  wire                          cfg_we,
  input  wire [CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire [CFG_DATA_BITS-1:0]      cfg_wdata,
  // pixel input
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire signed [PIXEL_BITS-1:0]  in_pixel,
  // result output
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [SUM_BITS-1:0]   out_sum,
  output logic                         out_last_of_plane
);

  localparam int CB          = $clog2(MAX_WIDTH);
  localparam int JOB_BITS    = 9 * PIXEL_BITS + 1;
  localparam int QUEUE_DEPTH = 4;

  logic [CB-1:0]       col_last_r, col_last_nxt;
  logic [ROW_BITS-1:0] row_last_r, row_last_nxt;
  outdim_t             odim_r, odim_nxt;
  kern_t               kern_r, kern_nxt;
  logic                restart;
  logic [IN_WIDTH_BITS-1:0]  wval;
  logic [IN_HEIGHT_BITS-1:0] hval;

  logic                job_push;
  logic [JOB_BITS-1:0] job_data;
  logic [JOB_BITS-1:0] q_data;
  logic                q_full, q_empty, q_pop;

  assign wval = cfg_wdata[IN_WIDTH_BITS-1:0];
  assign hval = cfg_wdata[IN_HEIGHT_BITS-1:0];

  // register writes; geometry is held as last column and last row
  always_comb begin
    col_last_nxt = col_last_r;
    row_last_nxt = row_last_r;
    odim_nxt     = odim_r;
    kern_nxt     = kern_r;
    restart      = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_WIDTH: begin
          restart = 1'b1;
          if (wval == '0) begin
            col_last_nxt = '0;
          end else if (32'(wval) > MAX_WIDTH) begin
            col_last_nxt = CB'(MAX_WIDTH - 1);
          end else begin
            col_last_nxt = CB'(wval - IN_WIDTH_BITS'(1));
          end
        end
        REG_IN_HEIGHT: begin
          restart = 1'b1;
          if (hval == '0) begin
            row_last_nxt = '0;
          end else if (32'(hval) > MAX_HEIGHT) begin
            row_last_nxt = ROW_BITS'(MAX_HEIGHT - 1);
          end else begin
            row_last_nxt = ROW_BITS'(hval - IN_HEIGHT_BITS'(1));
          end
        end
        REG_OUT_WIDTH:     odim_nxt.out_width  = cfg_wdata[OUT_WIDTH_BITS-1:0];
        REG_OUT_HEIGHT:    odim_nxt.out_height = cfg_wdata[OUT_HEIGHT_BITS-1:0];
        REG_KERNEL_TOP:    kern_nxt.top        = cfg_wdata[KERNEL_BITS-1:0];
        REG_KERNEL_MIDDLE: kern_nxt.middle     = cfg_wdata[KERNEL_BITS-1:0];
        REG_KERNEL_BOTTOM: kern_nxt.bottom     = cfg_wdata[KERNEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r        <= CB'(2);
      row_last_r        <= ROW_BITS'(2);
      odim_r.out_width  <= OUT_WIDTH_BITS'(1);
      odim_r.out_height <= OUT_HEIGHT_BITS'(1);
      kern_r            <= '0;
    end else begin
      col_last_r <= col_last_nxt;
      row_last_r <= row_last_nxt;
      odim_r     <= odim_nxt;
      kern_r     <= kern_nxt;
    end
  end

  // front end
  dwc3s2_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (restart),
    .col_last (col_last_r),
    .row_last (row_last_r),
    .odim     (odim_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pixel (in_pixel),
    .q_full   (q_full),
    .job_push (job_push),
    .job_data (job_data)
  );

  // window queue
  dwc3s2_queue #(
    .WIDTH (JOB_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_data),
    .pop   (q_pop),
    .rdata (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  // back end
  dwc3s2_back #(
    .PIXEL_BITS  (PIXEL_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .kern              (kern_r),
    .q_data            (q_data),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sum           (out_sum),
    .out_last_of_plane (out_last_of_plane)
  );

`ifndef NO_ASSERTIONS
  // a window is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_push && q_full))
    else $error("window pushed into full queue");

  // the back end only pops a queued window
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  // no result is presented right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
`default_nettype wire
